[sv/svam_pkg.sv]
// ----------------------------------------------------------------------------
// svam_pkg
// Shared types and constants of the voice allocator and peak mixer.
// ----------------------------------------------------------------------------
package svam_pkg;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_TICK  = 2'd3
   } svam_op_type;

   localparam logic KIND_START  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam int SOUND_W  = 8;
   localparam int REM_W    = 16;
   localparam int GAIN_W   = 4;
   localparam int BYTE_W   = 8;
   localparam int VNUM_W   = 4;
   localparam int PROD_W   = BYTE_W + GAIN_W;

   localparam logic [GAIN_W-1:0] GAIN_MAX      = 4'd15;
   localparam logic [BYTE_W-1:0] SAMPLE_OFFSET = 8'd128;

   // x/15 == (x*2185)>>15 for every x below 15*256
   localparam logic [PROD_W-1:0] RECIP_15    = 12'd2185;
   localparam int                RECIP_SHIFT = 15;

   typedef struct packed {
      logic clear;   // start of a tick: zero the peak
      logic take;    // a voice byte and gain are on the inputs
   } svam_mix_ctl_type;

endpackage

[sv/svam_sample_mem.sv]
// ----------------------------------------------------------------------------
// svam_sample_mem
// Byte sample memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module svam_sample_mem #(
   parameter int ADDR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [7:0]           wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [7:0]           rd_data
);
   import svam_pkg::*;

   logic [BYTE_W-1:0] mem [2**ADDR_BITS];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/svam_voice_mem.sv]
// ----------------------------------------------------------------------------
// svam_voice_mem
// Voice table: sound id, bytes left, gain and read address per voice.
// Valid bits make a never-written or stopped voice read as all zero.
// ----------------------------------------------------------------------------
module svam_voice_mem #(
   parameter int NUM_VOICES = 8,
   parameter int ADDR_BITS  = 16,
   parameter int VIW        = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [VIW-1:0]       rd_idx,
   output logic [7:0]           rd_sound,
   output logic [15:0]          rd_rem,
   output logic [3:0]           rd_gain,
   output logic [ADDR_BITS-1:0] rd_addr,
   input  logic                 wr_en,
   input  logic [VIW-1:0]       wr_idx,
   input  logic [7:0]           wr_sound,
   input  logic [15:0]          wr_rem,
   input  logic [3:0]           wr_gain,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic                 clr_en,
   input  logic [VIW-1:0]       clr_idx
);
   import svam_pkg::*;

   localparam int ENT_W = SOUND_W + REM_W + GAIN_W + ADDR_BITS;

   logic [ENT_W-1:0]      mem [NUM_VOICES];
   logic [NUM_VOICES-1:0] valid_ff;
   logic [NUM_VOICES-1:0] valid_in;
   logic [ENT_W-1:0]      rd_ent_ff;
   logic                  rd_valid_ff;
   logic [ENT_W-1:0]      rd_ent;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= {wr_sound, wr_rem, wr_gain, wr_addr};
      end
      if (rd_en) begin
         rd_ent_ff   <= mem[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
      if (clr_en) begin
         valid_in[clr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_ent = rd_valid_ff ? rd_ent_ff : '0;
   assign {rd_sound, rd_rem, rd_gain, rd_addr} = rd_ent;

endmodule

[sv/svam_mix.sv]
// ----------------------------------------------------------------------------
// svam_mix
// Tick datapath: offset byte, scale by gain/15, keep the running peak.
// ----------------------------------------------------------------------------
module svam_mix (
   input  logic                       clock,
   input  logic                       reset,
   input  svam_pkg::svam_mix_ctl_type ctl,
   input  logic [7:0]                 sample,
   input  logic [3:0]                 gain,
   output logic [7:0]                 peak
);
   import svam_pkg::*;

   localparam int QP_W = 2 * PROD_W;

   logic                  take1_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic                  take2_ff;
   logic [BYTE_W-1:0]     quot_ff;
   logic [BYTE_W-1:0]     peak_ff;
   logic [BYTE_W-1:0]     offs;
   logic [QP_W-1:0]       recip_prod;

   assign offs       = sample - SAMPLE_OFFSET;
   assign recip_prod = QP_W'(prod_ff) * QP_W'(RECIP_15);

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(offs) * PROD_W'(gain);
      quot_ff <= BYTE_W'(recip_prod >> RECIP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         take1_ff <= 1'b0;
         take2_ff <= 1'b0;
         peak_ff  <= '0;
      end else begin
         take1_ff <= ctl.take;
         take2_ff <= take1_ff;
         if (ctl.clear) begin
            peak_ff <= '0;
         end else if (take2_ff && (quot_ff > peak_ff)) begin
            peak_ff <= quot_ff;
         end
      end
   end

   assign peak = peak_ff;

endmodule

[sv/sound_voice_allocator_mixer_top.sv]
// ----------------------------------------------------------------------------
// sound_voice_allocator_mixer_top
// Voice allocator and peak mixer over a byte sample memory and a voice table.
// ----------------------------------------------------------------------------
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tuser opcode, tdata load/start/stop
//   rsp      out  rsp_tvalid/tready     tuser kind, tdata voice and sample
//
// Load and stop are done in the idle state. Start scans the voice table from
// the search base, one read per cycle, then reads and rewrites the chosen
// voice. Tick walks all voices through the table and the sample memory and
// a two-stage scaler.
// Reset clears the voice valid bits; the sample memory is not cleared.
// A result waits in the output register; the next word is taken meanwhile,
// and a following result holds the sequencer until that register is free.
// ----------------------------------------------------------------------------
module sound_voice_allocator_mixer_top #(
   parameter int NUM_VOICES = 8,
   parameter int ADDR_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mem_address[15:0] mem_byte[23:16] sound_id[31:24] exclusive[32]
   // volume[40:33] sample_length[56:41] data_present[57] voice[61:58]
   input  logic [63:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // voice_given[3:0] sample_out[11:4]
   output logic [15:0] rsp_tdata,
   // kind[0]
   output logic [0:0]  rsp_tuser
);
   import svam_pkg::*;

   localparam int VIW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CW  = $clog2(NUM_VOICES + 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_SEL_RD = 7'b0000100,
      ST_SEL_WR = 7'b0001000,
      ST_TICK   = 7'b0010000,
      ST_DRAIN  = 7'b0100000,
      ST_PUSH   = 7'b1000000
   } state_type;

   function automatic logic [VIW-1:0] next_idx(input logic [VIW-1:0] i);
      return (i == VIW'(NUM_VOICES - 1)) ? '0 : VIW'(i + VIW'(1));
   endfunction

   // request fields
   logic [15:0]       f_addr;
   logic [7:0]        f_byte;
   logic [7:0]        f_id;
   logic              f_excl;
   logic signed [7:0] f_vol;
   logic [15:0]       f_len;
   logic              f_present;
   logic [3:0]        f_voice;
   svam_op_type       f_op;
   logic [3:0]        vol_clamped;
   logic              stop_ok;
   logic              req_acc;

   assign f_addr    = req_tdata[15:0];
   assign f_byte    = req_tdata[23:16];
   assign f_id      = req_tdata[31:24];
   assign f_excl    = req_tdata[32];
   assign f_vol     = req_tdata[40:33];
   assign f_len     = req_tdata[56:41];
   assign f_present = req_tdata[57];
   assign f_voice   = req_tdata[61:58];
   assign f_op      = svam_op_type'(req_tuser);

   always_comb begin
      priority if (f_vol[7]) begin
         vol_clamped = '0;
      end else if (f_vol > 8'sd15) begin
         vol_clamped = GAIN_MAX;
      end else begin
         vol_clamped = f_vol[3:0];
      end
   end

   assign stop_ok = (f_voice != 4'd0) && ({1'b0, f_voice} <= 5'(NUM_VOICES));

   // sequencer state
   state_type            state_ff, state_in;
   logic [7:0]           id_ff, id_in;
   logic                 excl_ff, excl_in;
   logic [3:0]           gain_ff, gain_in;
   logic [15:0]          len_ff, len_in;
   logic                 present_ff, present_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [VIW-1:0]       base_ff, base_in;
   logic [VIW-1:0]       issue_idx_ff, issue_idx_in;
   logic [CW-1:0]        issue_cnt_ff, issue_cnt_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [VIW-1:0]       rd_idx_ff, rd_idx_in;
   logic [CW-1:0]        chk_cnt_ff, chk_cnt_in;
   logic [VIW-1:0]       chosen_ff, chosen_in;
   logic                 tk_act_ff, tk_act_in;
   logic [3:0]           tk_gain_ff, tk_gain_in;
   logic                 any_ff, any_in;
   logic [1:0]           drain_ff, drain_in;
   logic                 res_kind_ff, res_kind_in;
   logic [3:0]           res_voice_ff, res_voice_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [3:0]           rsp_voice_ff, rsp_voice_in;
   logic [7:0]           rsp_sample_ff, rsp_sample_in;

   // memory and mixer hookup
   logic                 sm_wr_en, sm_rd_en;
   logic [ADDR_BITS-1:0] sm_rd_addr;
   logic [7:0]           sm_rd_data;
   logic                 vm_rd_en, vm_wr_en, vm_clr_en;
   logic [VIW-1:0]       vm_rd_idx, vm_wr_idx, vm_clr_idx;
   logic [7:0]           vm_rd_sound, vm_wr_sound;
   logic [15:0]          vm_rd_rem, vm_wr_rem;
   logic [3:0]           vm_rd_gain, vm_wr_gain;
   logic [ADDR_BITS-1:0] vm_rd_addr, vm_wr_addr;
   svam_mix_ctl_type     mix_ctl;
   logic [7:0]           mix_peak;
   logic                 hit;
   logic                 take_new;
   logic                 rd_active;

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      id_in         = id_ff;
      excl_in       = excl_ff;
      gain_in       = gain_ff;
      len_in        = len_ff;
      present_in    = present_ff;
      addr_in       = addr_ff;
      base_in       = base_ff;
      issue_idx_in  = issue_idx_ff;
      issue_cnt_in  = issue_cnt_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      chk_cnt_in    = chk_cnt_ff;
      chosen_in     = chosen_ff;
      any_in        = any_ff;
      drain_in      = drain_ff;
      res_kind_in   = res_kind_ff;
      res_voice_in  = res_voice_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_voice_in  = rsp_voice_ff;
      rsp_sample_in = rsp_sample_ff;

      sm_wr_en      = 1'b0;
      sm_rd_en      = 1'b0;
      sm_rd_addr    = vm_rd_addr;
      vm_rd_en      = 1'b0;
      vm_rd_idx     = issue_idx_ff;
      vm_wr_en      = 1'b0;
      vm_wr_idx     = rd_idx_ff;
      vm_wr_sound   = vm_rd_sound;
      vm_wr_rem     = vm_rd_rem - 16'd1;
      vm_wr_gain    = vm_rd_gain;
      vm_wr_addr    = vm_rd_addr + ADDR_BITS'(1);
      vm_clr_en     = 1'b0;
      vm_clr_idx    = VIW'(f_voice - 4'd1);
      mix_ctl       = '0;
      hit           = (vm_rd_rem == 16'd0) || (excl_ff && (vm_rd_sound == id_ff));
      take_new      = (gain_ff != 4'd0) && present_ff;
      rd_active     = vm_rd_rem != 16'd0;
      tk_act_in     = 1'b0;
      tk_gain_in    = vm_rd_gain;

      // voice byte fetch and table advance, in the cycle after each tick read
      if (((state_ff == ST_TICK) || (state_ff == ST_DRAIN)) && rd_pend_ff && rd_active) begin
         sm_rd_en  = 1'b1;
         vm_wr_en  = 1'b1;
         any_in    = 1'b1;
         tk_act_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               id_in        = f_id;
               excl_in      = f_excl;
               gain_in      = vol_clamped;
               len_in       = f_len;
               present_in   = f_present;
               addr_in      = ADDR_BITS'(f_addr);
               issue_cnt_in = '0;
               chk_cnt_in   = '0;
               unique case (f_op)
                  OP_LOAD: begin
                     sm_wr_en = 1'b1;
                  end
                  OP_STOP: begin
                     vm_clr_en = stop_ok;
                  end
                  OP_START: begin
                     issue_idx_in = base_ff;
                     state_in     = ST_SCAN;
                  end
                  OP_TICK: begin
                     issue_idx_in  = '0;
                     any_in        = 1'b0;
                     mix_ctl.clear = 1'b1;
                     state_in      = ST_TICK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_cnt_ff != CW'(NUM_VOICES)) begin
               vm_rd_en     = 1'b1;
               issue_idx_in = next_idx(issue_idx_ff);
               issue_cnt_in = issue_cnt_ff + CW'(1);
               rd_pend_in   = 1'b1;
               rd_idx_in    = issue_idx_ff;
            end
            if (rd_pend_ff) begin
               chk_cnt_in = chk_cnt_ff + CW'(1);
               priority if (hit) begin
                  chosen_in = rd_idx_ff;
                  state_in  = ST_SEL_RD;
               end else if (chk_cnt_ff == CW'(NUM_VOICES - 1)) begin
                  // nothing free: take the voice the search started at
                  chosen_in = base_ff;
                  state_in  = ST_SEL_RD;
               end else begin
               end
            end
         end
         ST_SEL_RD: begin
            vm_rd_en  = 1'b1;
            vm_rd_idx = chosen_ff;
            state_in  = ST_SEL_WR;
         end
         ST_SEL_WR: begin
            vm_wr_en     = 1'b1;
            vm_wr_idx    = chosen_ff;
            vm_wr_sound  = id_ff;
            vm_wr_gain   = (gain_ff == 4'd0) ? vm_rd_gain : gain_ff;
            vm_wr_rem    = take_new ? len_ff : vm_rd_rem;
            vm_wr_addr   = take_new ? addr_ff : vm_rd_addr;
            base_in      = next_idx(chosen_ff);
            res_kind_in  = KIND_START;
            res_voice_in = (gain_ff == 4'd0) ? 4'd0 : VNUM_W'(chosen_ff) + 4'd1;
            state_in     = ST_PUSH;
         end
         ST_TICK: begin
            if (issue_cnt_ff != CW'(NUM_VOICES)) begin
               vm_rd_en     = 1'b1;
               issue_idx_in = next_idx(issue_idx_ff);
               issue_cnt_in = issue_cnt_ff + CW'(1);
               rd_pend_in   = 1'b1;
               rd_idx_in    = issue_idx_ff;
            end else begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the scaler pipe to settle the peak
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'd2) begin
               res_kind_in  = KIND_SAMPLE;
               res_voice_in = '0;
               state_in     = any_ff ? ST_PUSH : ST_IDLE;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = res_kind_ff;
               rsp_voice_in  = res_voice_ff;
               rsp_sample_in = (res_kind_ff == KIND_SAMPLE) ? mix_peak : 8'd0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      mix_ctl.take = tk_act_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         issue_cnt_ff <= '0;
         chk_cnt_ff   <= '0;
         tk_act_ff    <= 1'b0;
         any_ff       <= 1'b0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         rd_pend_ff   <= rd_pend_in;
         issue_cnt_ff <= issue_cnt_in;
         chk_cnt_ff   <= chk_cnt_in;
         tk_act_ff    <= tk_act_in;
         any_ff       <= any_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      excl_ff       <= excl_in;
      gain_ff       <= gain_in;
      len_ff        <= len_in;
      present_ff    <= present_in;
      addr_ff       <= addr_in;
      issue_idx_ff  <= issue_idx_in;
      rd_idx_ff     <= rd_idx_in;
      chosen_ff     <= chosen_in;
      tk_gain_ff    <= tk_gain_in;
      res_kind_ff   <= res_kind_in;
      res_voice_ff  <= res_voice_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_voice_ff  <= rsp_voice_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   svam_sample_mem #(
      .ADDR_BITS (ADDR_BITS)
   ) u_sample_mem (
      .clock   (clock),
      .wr_en   (sm_wr_en),
      .wr_addr (ADDR_BITS'(f_addr)),
      .wr_data (f_byte),
      .rd_en   (sm_rd_en),
      .rd_addr (sm_rd_addr),
      .rd_data (sm_rd_data)
   );

   svam_voice_mem #(
      .NUM_VOICES (NUM_VOICES),
      .ADDR_BITS  (ADDR_BITS),
      .VIW        (VIW)
   ) u_voice_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (vm_rd_en),
      .rd_idx   (vm_rd_idx),
      .rd_sound (vm_rd_sound),
      .rd_rem   (vm_rd_rem),
      .rd_gain  (vm_rd_gain),
      .rd_addr  (vm_rd_addr),
      .wr_en    (vm_wr_en),
      .wr_idx   (vm_wr_idx),
      .wr_sound (vm_wr_sound),
      .wr_rem   (vm_wr_rem),
      .wr_gain  (vm_wr_gain),
      .wr_addr  (vm_wr_addr),
      .clr_en   (vm_clr_en),
      .clr_idx  (vm_clr_idx)
   );

   svam_mix u_mix (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mix_ctl),
      .sample (sm_rd_data),
      .gain   (tk_gain_ff),
      .peak   (mix_peak)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_sample_ff, rsp_voice_ff};
   assign rsp_tuser  = rsp_kind_ff;

endmodule
